/* rtl/core/qta_pkg.sv */
`timescale 1ns / 1ps

package qta_pkg;

	// Sequencer states of the tree walk.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_EVAL,
		ST_NEXT,
		ST_POP,
		ST_HIT
	} qta_state_t;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 17;
	localparam int SizeW    = 17;
	localparam int MapLog2W = 5;
	localparam int LevelW   = 3;

	localparam logic [CfgIdxW-1:0] CFG_MAP_SIZE_LOG2 = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_NUM_LEVELS    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_TILE_SIZE = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// Node count of a complete quadtree with the given number of levels:
	// (4^levels - 1) / 3, which in binary is levels pairs of 01.
	function automatic logic [31:0] node_span(input int unsigned levels);
		logic [31:0] r;
		r = '0;
		for (int j = 0; j < 16; j++) begin
			if (j < levels) begin
				r[2*j] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

/* rtl/core/qta_node_ram.sv */
`timescale 1ns / 1ps

module qta_node_ram #(
	parameter int DEPTH = 1365,
	parameter int AW    = 11,
	parameter int DW    = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/quadtree_tile_allocator.sv */
`timescale 1ns / 1ps

// Quadtree tile allocator for a square shadow map.
// A transaction is started by holding start high while busy is low; req_type
// selects an allocation or a clear of the whole tree. Exactly one result per
// transaction appears on found, node_level, pos_x, pos_y and clamped_size,
// valid for the single cycle in which done is high. The receiver cannot stall.
// An allocation takes a set-up step, a read and an evaluate step for every node
// read during the depth-first walk, a step per sibling move or return to a
// parent, and a final step to update the parent on a hit; the node memory has a
// single read port. A clear sweeps the node memory one entry a cycle, writing
// all NodeCount entries. The result comes in the cycle after the last busy
// cycle, and a new transaction may be taken in that same cycle. After reset the
// same sweep runs with busy high and no result. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at the next edge and are accepted at
// any time, but must only be made while the block is idle.
module quadtree_tile_allocator
	import qta_pkg::*;
#(
	parameter int MAX_LEVELS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CfgIdxW-1:0]           cfg_index,
	input  logic [CfgDataW-1:0]          cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [SizeW-1:0]             tile_size,
	output logic                         done,
	output logic                         found,
	output logic [LevelW-1:0]            node_level,
	output logic signed [MAX_LEVELS-1:0] pos_x,
	output logic signed [MAX_LEVELS-1:0] pos_y,
	output logic [SizeW-1:0]             clamped_size
);

	localparam int NodeCount = int'(node_span(MAX_LEVELS));
	localparam int AW        = $clog2(NodeCount);
	localparam int LW        = $clog2(MAX_LEVELS);
	localparam int PW        = MAX_LEVELS;

	function automatic logic [MapLog2W-1:0] ceil_log2(input logic [SizeW-1:0] v);
		logic [MapLog2W-1:0] r;
		r = '0;
		for (int k = SizeW; k >= 0; k--) begin
			if ({1'b0, v} <= ((SizeW+1)'(1) << k)) begin
				r = MapLog2W'(k);
			end
		end
		return r;
	endfunction

	function automatic logic [PW-1:0] step_at(input logic [LevelW-1:0] lv);
		int unsigned sh;
		sh = MAX_LEVELS - 1 - int'(lv);
		return PW'(1) << sh;
	endfunction

	// Configuration registers.
	logic [MapLog2W-1:0] map_log2_q;
	logic [2:0]          num_levels_q;
	logic [SizeW-1:0]    max_tile_q;

	qta_state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic          emit_q;
	logic          done_q;
	logic          done_d;

	// Walk context.
	logic [SizeW-1:0]     tsize_q;
	logic [LevelW-1:0]    want_q;
	logic [LevelW-1:0]    cl_q;
	logic [AW-1:0]        idx_q;
	logic signed [PW-1:0] px_q, py_q;
	logic [AW-1:0]        path_q   [MAX_LEVELS];
	logic [1:0]           ichild_q [MAX_LEVELS];

	// Result registers.
	logic                 found_q;
	logic [LevelW-1:0]    level_q;
	logic signed [PW-1:0] rx_q, ry_q;
	logic [SizeW-1:0]     size_q;

	// Memory control.
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr;
	logic [2:0]    mem_wdata, mem_rdata;

	logic [LevelW-1:0]   eff_levels;
	logic [LevelW-1:0]   lvm1;
	logic [LW-1:0]       cur_ix, par_ix, nxt_ix;
	logic [1:0]          ichild_cur;
	logic [AW-1:0]       span_cur;
	logic [PW-1:0]       step_cur, step_nxt;
	logic [MapLog2W-1:0] small_exp;
	logic [SizeW-1:0]    raised, clamped;
	logic [MapLog2W-1:0] size_lg, want_w;
	logic                alloc_ok;
	logic                eval_skip, eval_hit;
	logic                clr_last;
	logic                accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		if (num_levels_q == 3'd0) begin
			eff_levels = 3'd1;
		end else if ({1'b0, num_levels_q} > 4'(MAX_LEVELS)) begin
			eff_levels = 3'(MAX_LEVELS);
		end else begin
			eff_levels = num_levels_q;
		end
	end

	// Clamp the request, then turn its side into a tree level.
	always_comb begin
		if (map_log2_q >= MapLog2W'(eff_levels - 3'd1)) begin
			small_exp = map_log2_q - MapLog2W'(eff_levels - 3'd1);
		end else begin
			small_exp = '0;
		end
		if (small_exp >= MapLog2W'(SizeW)) begin
			raised = max_tile_q;
		end else if (tsize_q < (SizeW'(1) << small_exp)) begin
			raised = SizeW'(1) << small_exp;
		end else begin
			raised = tsize_q;
		end
		clamped  = (raised > max_tile_q) ? max_tile_q : raised;
		size_lg  = ceil_log2(clamped);
		want_w   = map_log2_q - size_lg;
		alloc_ok = (size_lg <= map_log2_q) && (want_w != '0) &&
			(want_w < MapLog2W'(eff_levels));
	end

	assign lvm1       = cl_q - 3'd1;
	assign cur_ix     = cl_q[LW-1:0];
	assign par_ix     = lvm1[LW-1:0];
	assign nxt_ix     = LW'(cl_q + 3'd1);
	assign ichild_cur = ichild_q[cur_ix];
	assign span_cur   = AW'(node_span(MAX_LEVELS - int'(cl_q)));
	assign step_cur   = step_at(cl_q);
	assign step_nxt   = step_at(cl_q + 3'd1);
	assign eval_skip  = want_q < mem_rdata;
	assign eval_hit   = want_q == cl_q;
	assign clr_last   = clr_q == AW'(NodeCount - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = (req_type == REQ_CLEAR) ? ST_CLEAR : ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = alloc_ok ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (eval_skip) begin
					state_d = ST_NEXT;
				end else if (eval_hit) begin
					state_d = ST_HIT;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_NEXT: begin
				state_d = (ichild_cur == 2'd3) ? ST_POP : ST_READ;
			end
			ST_POP: begin
				state_d = (cl_q == 3'd1) ? ST_IDLE : ST_NEXT;
			end
			ST_HIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		done_d    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				done_d    = clr_last && emit_q;
			end
			ST_SETUP: begin
				done_d = !alloc_ok;
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_EVAL: begin
				// Closing the taken node.
				if (!eval_skip && eval_hit) begin
					mem_we    = 1'b1;
					mem_wdata = eff_levels;
				end
			end
			ST_POP: begin
				done_d = cl_q == 3'd1;
			end
			ST_HIT: begin
				mem_we    = 1'b1;
				mem_waddr = path_q[par_ix];
				mem_wdata = want_q;
				done_d    = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			emit_q       <= 1'b0;
			done_q       <= 1'b0;
			map_log2_q   <= 5'd10;
			num_levels_q <= 3'd6;
			max_tile_q   <= 17'd1024;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				clr_q  <= '0;
				emit_q <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAP_SIZE_LOG2: map_log2_q   <= cfg_data[MapLog2W-1:0];
					CFG_NUM_LEVELS:    num_levels_q <= cfg_data[2:0];
					CFG_MAX_TILE_SIZE: max_tile_q   <= cfg_data;
					default:           map_log2_q   <= map_log2_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					tsize_q <= tile_size;
					found_q <= 1'b0;
					level_q <= '0;
					rx_q    <= '0;
					ry_q    <= '0;
					size_q  <= '0;
				end
			end
			ST_SETUP: begin
				size_q           <= clamped;
				want_q           <= want_w[LevelW-1:0];
				cl_q             <= 3'd1;
				idx_q            <= AW'(1);
				path_q[0]        <= '0;
				ichild_q[LW'(1)] <= 2'd0;
				px_q             <= -$signed(step_at(3'd1));
				py_q             <= $signed(step_at(3'd1));
			end
			ST_EVAL: begin
				if (!eval_skip && eval_hit) begin
					found_q <= 1'b1;
					level_q <= cl_q;
					rx_q    <= px_q;
					ry_q    <= py_q;
				end else if (!eval_skip) begin
					// Descend to the first child, which sits at (-x, +y).
					path_q[cur_ix]   <= idx_q;
					ichild_q[nxt_ix] <= 2'd0;
					cl_q             <= cl_q + 3'd1;
					idx_q            <= idx_q + AW'(1);
					px_q             <= px_q - $signed(step_nxt);
					py_q             <= py_q + $signed(step_nxt);
				end
			end
			ST_NEXT: begin
				if (ichild_cur != 2'd3) begin
					idx_q            <= idx_q + span_cur;
					ichild_q[cur_ix] <= ichild_cur + 2'd1;
					case (ichild_cur)
						2'd0:    py_q <= py_q - $signed(step_cur << 1);
						2'd1:    px_q <= px_q + $signed(step_cur << 1);
						default: py_q <= py_q + $signed(step_cur << 1);
					endcase
				end
			end
			ST_POP: begin
				// The last child sits at (+x, +y) from its parent.
				idx_q <= path_q[par_ix];
				cl_q  <= lvm1;
				px_q  <= px_q - $signed(step_cur);
				py_q  <= py_q - $signed(step_cur);
			end
			default: begin
				cl_q <= cl_q;
			end
		endcase
	end

	qta_node_ram #(
		.DEPTH (NodeCount),
		.AW    (AW),
		.DW    (3)
	) u_node_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign found        = found_q;
	assign node_level   = level_q;
	assign pos_x        = rx_q;
	assign pos_y        = ry_q;
	assign clamped_size = size_q;

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE)
		else $error("result strobe outside the idle state");

	a_found_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> $past(state_q == ST_HIT))
		else $error("allocation reported without a parent update");

	a_found_level: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> node_level != 3'd0 && node_level < eff_levels)
		else $error("allocated level outside the tree");

	a_walk_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_EVAL) |-> cl_q != 3'd0 && cl_q <= want_q)
		else $error("walk went below the requested level");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> clr_q <= AW'(NodeCount - 1))
		else $error("clearing sweep ran past the node memory");

endmodule

/* tb/quadtree_tile_allocator_test.sv */
`timescale 1ns / 1ps

module quadtree_tile_allocator_test;
	import qta_pkg::*;

	localparam int MaxLevels = 6;
	localparam int PosW = MaxLevels;
	localparam int NodeCount = ((1 << (2 * MaxLevels)) - 1) / 3;
	localparam int RandomItems = 590;
	localparam longint CycleLimit = 64'd20_000_000;
	localparam int TailCycles = 100;
	localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic                    found;
		logic [LevelW-1:0]       level;
		logic signed [PosW-1:0]  px;
		logic signed [PosW-1:0]  py;
		logic [SizeW-1:0]        csize;
	} tile_result_t;

	typedef struct packed {
		logic             kind;
		logic [SizeW-1:0] size;
		logic             drain;
	} tile_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic req_type = REQ_ALLOC;
	logic [SizeW-1:0] tile_size = '0;
	logic busy;
	logic done;
	logic found;
	logic [LevelW-1:0] node_level;
	logic signed [PosW-1:0] pos_x;
	logic signed [PosW-1:0] pos_y;
	logic [SizeW-1:0] clamped_size;

	// Shadow copy of the configuration and of the per-node minimum levels.
	logic [MapLog2W-1:0] map_log2_q = 5'd10;
	logic [LevelW-1:0] levels_q = 3'd6;
	logic [SizeW-1:0] max_tile_q = 17'd1024;
	logic [LevelW-1:0] tree_min [NodeCount];

	tile_req_t req_backlog [$];
	tile_result_t tile_expect_q [$];
	int unsigned n_issued = 0;
	int unsigned n_seen = 0;
	int unsigned failures = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	longint unsigned cycles = 0;
	int unsigned random_sent = 0;
	tile_req_t next_req;
	tile_result_t exp_r;

	quadtree_tile_allocator #(
		.MAX_LEVELS(MaxLevels)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.tile_size(tile_size),
		.done(done),
		.found(found),
		.node_level(node_level),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.clamped_size(clamped_size)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned used_levels();
		int unsigned eff;
		eff = 32'(levels_q);
		if (eff < 1) eff = 1;
		if (eff > MaxLevels) eff = MaxLevels;
		return eff;
	endfunction

	// Depth-first preorder search with an explicit stack in place of recursion.
	function automatic tile_result_t place_tile(input logic [SizeW-1:0] req_size);
		tile_result_t r;
		int unsigned eff, lg, want, d, cl, idx, span;
		longint unsigned smallest, sz;
		int s, cx, cy;
		int unsigned par_idx [MaxLevels];
		int unsigned child [MaxLevels];
		int ctr_x [MaxLevels];
		int ctr_y [MaxLevels];
		bit searching;
		r = '0;
		eff = used_levels();
		smallest = (64'd1 << map_log2_q) >> (eff - 1);
		if (smallest == 0) smallest = 1;
		sz = 64'(req_size);
		if (sz < smallest) sz = smallest;
		if (sz > max_tile_q) sz = 64'(max_tile_q);
		r.csize = sz[SizeW-1:0];
		lg = 0;
		while (lg < 63 && (64'd1 << lg) < sz) lg++;
		if (lg > map_log2_q) return r;
		want = map_log2_q - lg;
		if (want == 0 || want >= eff) return r;
		d = 0;
		par_idx[0] = 0;
		child[0] = 0;
		ctr_x[0] = 0;
		ctr_y[0] = 0;
		searching = 1'b1;
		while (searching) begin
			cl = d + 1;
			if (child[d] == 4 || cl >= eff) begin
				if (d == 0) begin
					searching = 1'b0;
				end else begin
					d--;
					child[d]++;
				end
			end else begin
				span = ((1 << (2 * (MaxLevels - cl))) - 1) / 3;
				idx = par_idx[d] + 1 + child[d] * span;
				s = 1 << (MaxLevels - 1 - cl);
				cx = ctr_x[d] + ((child[d] < 2) ? -s : s);
				cy = ctr_y[d] + ((child[d] == 0 || child[d] == 3) ? s : -s);
				if (want < tree_min[idx]) begin
					child[d]++;
				end else if (want == cl) begin
					tree_min[par_idx[d]] = want[LevelW-1:0];
					tree_min[idx] = eff[LevelW-1:0];
					r.found = 1'b1;
					r.level = cl[LevelW-1:0];
					r.px = cx[PosW-1:0];
					r.py = cy[PosW-1:0];
					searching = 1'b0;
				end else if (want > cl) begin
					d++;
					par_idx[d] = idx;
					child[d] = 0;
					ctr_x[d] = cx;
					ctr_y[d] = cy;
				end else begin
					child[d]++;
				end
			end
		end
		return r;
	endfunction

	function automatic tile_result_t predict_request(input logic kind,
			input logic [SizeW-1:0] req_size);
		if (kind == REQ_CLEAR) begin
			foreach (tree_min[i]) tree_min[i] = '0;
			return '0;
		end
		return place_tile(req_size);
	endfunction

	// Most sizes land on a reachable level so that the walk gets deep.
	function automatic logic [SizeW-1:0] pick_size();
		int unsigned eff, lvl, hi, lo;
		eff = used_levels();
		case ($urandom_range(0, 9))
			0: begin
				return SizeW'($urandom_range(0, 16));
			end
			1: begin
				return SizeW'($urandom);
			end
			2: begin
				return SizeW'($urandom_range(1, 65536));
			end
			default: begin
				lvl = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
				hi = (1 << map_log2_q) >> lvl;
				if (hi == 0) return SizeW'(1);
				lo = (hi >> 1) + 1;
				return SizeW'($urandom_range(lo, hi));
			end
		endcase
	endfunction

	task automatic queue_req(input logic kind, input logic [SizeW-1:0] size,
			input logic drain = 1'b0);
		tile_req_t t;
		t.kind = kind;
		t.size = size;
		t.drain = drain;
		req_backlog.push_back(t);
	endtask

	// Checked at the falling edge, when every rising-edge update has settled.
	task automatic wait_idle();
		do @(negedge clk);
		while (!(req_backlog.size() == 0 && !start && n_seen == n_issued && !busy));
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_MAP_SIZE_LOG2: map_log2_q = data[MapLog2W-1:0];
			CFG_NUM_LEVELS:    levels_q = data[LevelW-1:0];
			CFG_MAX_TILE_SIZE: max_tile_q = data[SizeW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CfgDataW-1:0] map_log2,
			input logic [CfgDataW-1:0] levels, input logic [CfgDataW-1:0] max_tile);
		wait_idle();
		write_reg(CFG_MAP_SIZE_LOG2, map_log2);
		write_reg(CFG_NUM_LEVELS, levels);
		write_reg(CFG_MAX_TILE_SIZE, max_tile);
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_SPARE, CfgDataW'($urandom));
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Sender: holds a transaction until it is taken, then works in bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				tile_expect_q.push_back(predict_request(req_type, tile_size));
				n_issued++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (req_backlog.size() > 0 &&
						!(req_backlog[0].drain && n_seen != n_issued)) begin
					next_req = req_backlog.pop_front();
					start <= 1'b1;
					req_type <= next_req.kind;
					tile_size <= next_req.size;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 8);
							default: gap_left = $urandom_range(10, 400);
						endcase
					end else begin
						burst_left--;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (tile_expect_q.size() == 0) begin
				$error("result transaction with no request outstanding");
				failures++;
			end else begin
				exp_r = tile_expect_q.pop_front();
				if (found !== exp_r.found) begin
					$error("found: expected %0d, actual %0d", exp_r.found, found);
					failures++;
				end
				if (node_level !== exp_r.level) begin
					$error("node_level: expected %0d, actual %0d", exp_r.level, node_level);
					failures++;
				end
				if (pos_x !== exp_r.px) begin
					$error("pos_x: expected %0d, actual %0d", exp_r.px, pos_x);
					failures++;
				end
				if (pos_y !== exp_r.py) begin
					$error("pos_y: expected %0d, actual %0d", exp_r.py, pos_y);
					failures++;
				end
				if (clamped_size !== exp_r.csize) begin
					$error("clamped_size: expected %0d, actual %0d", exp_r.csize,
						clamped_size);
					failures++;
				end
			end
			n_seen <= n_seen + 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned n, lv, mx;
		foreach (tree_min[i]) tree_min[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Reset configuration: smallest tile 32, largest 1024.
		queue_req(REQ_ALLOC, 17'd1);
		queue_req(REQ_ALLOC, 17'h1FFFF);
		queue_req(REQ_ALLOC, 17'd512);
		queue_req(REQ_ALLOC, 17'd300);
		queue_req(REQ_ALLOC, 17'd257);
		queue_req(REQ_ALLOC, 17'd256);
		queue_req(REQ_ALLOC, 17'd512);
		queue_req(REQ_ALLOC, 17'd0);
		queue_req(REQ_ALLOC, 17'd65536);
		queue_req(REQ_CLEAR, 17'h1FFFF);
		queue_req(REQ_ALLOC, 17'd33);

		// Largest tile below the smallest one: the cap wins.
		set_config(17'd16, 17'd2, 17'd16);
		queue_req(REQ_ALLOC, 17'd1);
		queue_req(REQ_ALLOC, 17'd65536);

		// Level count above the maximum, smallest tile saturating at one texel.
		set_config(17'd4, 17'd7, 17'd65536);
		queue_req(REQ_CLEAR, 17'd0);
		queue_req(REQ_ALLOC, 17'd1);
		queue_req(REQ_ALLOC, 17'd2);
		queue_req(REQ_ALLOC, 17'd65536);

		// Level count of zero through masked data, and a zero largest tile.
		set_config(17'h1FFE0 | 17'd10, 17'h1FFF8, 17'd0);
		queue_req(REQ_ALLOC, 17'd5);
		set_config(17'd10, 17'd6, 17'd0);
		queue_req(REQ_ALLOC, 17'd100, 1'b1);

		set_config(17'd16, 17'd6, 17'd65536);
		queue_req(REQ_CLEAR, 17'd0);
		queue_req(REQ_ALLOC, 17'd65536);
		queue_req(REQ_ALLOC, 17'd32768);
		queue_req(REQ_ALLOC, 17'd2048);
		queue_req(REQ_ALLOC, 17'd2049);

		while (random_sent < RandomItems) begin
			lv = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 0 : 7)
				: $urandom_range(1, 6);
			case ($urandom_range(0, 3))
				0: mx = 16;
				1: mx = 65536;
				2: mx = 1 << $urandom_range(4, 16);
				default: mx = $urandom_range(16, 65536);
			endcase
			set_config(CfgDataW'($urandom_range(0, 4) == 0 ? ($urandom_range(0, 1) ? 4 : 16)
				: $urandom_range(4, 16)), CfgDataW'(lv), CfgDataW'(mx));
			if ($urandom_range(0, 9) != 0) begin
				queue_req(REQ_CLEAR, SizeW'($urandom));
			end
			n = $urandom_range(15, 50);
			repeat (n) begin
				if ($urandom_range(0, 19) == 0) begin
					queue_req(REQ_CLEAR, SizeW'($urandom), 1'($urandom_range(0, 1)));
				end else begin
					queue_req(REQ_ALLOC, pick_size(), $urandom_range(0, 29) == 0);
				end
			end
			random_sent += n;
		end

		wait_idle();
		repeat (TailCycles) @(posedge clk);
		if (tile_expect_q.size() != 0) begin
			$error("%0d expected results never arrived", tile_expect_q.size());
			failures++;
		end
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
